/* sv/gbsc_pkg.sv */
// Types, codes and helper functions for the GIF block structure checker.
// Shared by gbsc_core and gif_block_structure_checker_unit; no dependencies.
package gbsc_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = ((OFFSET_BITS > CNT_W) ? OFFSET_BITS : CNT_W) + 1;
    localparam int SKIP_W      = 10;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [SKIP_W-1:0]      t_skip;
    typedef logic [SUM_W-1:0]       t_sum;

    localparam t_sum OFF_MAX_X = t_sum'({OFFSET_BITS{1'b1}});
    localparam t_cnt CNT_MAX   = {CNT_W{1'b1}};
    localparam t_sum CNT_MAX_X = t_sum'(CNT_MAX);

    typedef enum logic [3:0] {
        PH_SIG      = 4'd0,
        PH_VER      = 4'd1,
        PH_SCREEN   = 4'd2,
        PH_GCT      = 4'd3,
        PH_LABEL    = 4'd4,
        PH_EXTLABEL = 4'd5,
        PH_EXTSIZE  = 4'd6,
        PH_EXTSUB   = 4'd7,
        PH_IMGDESC  = 4'd8,
        PH_IMGSIZE  = 4'd9,
        PH_IMGSUB   = 4'd10
    } t_phase;

    localparam logic [3:0] V_OK            = 4'd0;
    localparam logic [3:0] V_NO_TRAILER    = 4'd1;
    localparam logic [3:0] V_NOT_GIF       = 4'd2;
    localparam logic [3:0] V_TRUNC_SCREEN  = 4'd3;
    localparam logic [3:0] V_TRUNC_GCT     = 4'd4;
    localparam logic [3:0] V_TRUNC_LABEL   = 4'd5;
    localparam logic [3:0] V_TRUNC_EXT     = 4'd6;
    localparam logic [3:0] V_TRUNC_EXTSUB  = 4'd7;
    localparam logic [3:0] V_TRUNC_IMGDESC = 4'd8;
    localparam logic [3:0] V_TRUNC_IMG     = 4'd9;
    localparam logic [3:0] V_BAD_LABEL     = 4'd10;

    localparam logic [7:0] SIG_G       = 8'h47;
    localparam logic [7:0] SIG_I       = 8'h49;
    localparam logic [7:0] SIG_F       = 8'h46;
    localparam logic [7:0] LBL_EXT     = 8'h21;
    localparam logic [7:0] LBL_IMAGE   = 8'h2C;
    localparam logic [7:0] LBL_TRAILER = 8'h3B;
    localparam logic [7:0] LBL_GCE     = 8'hF9;
    localparam logic [7:0] BLK_END     = 8'h00;

    localparam t_skip SKIP_VER    = 10'd3;
    localparam t_skip SKIP_SCREEN = 10'd7;
    localparam t_skip SKIP_FLAGS  = 10'd3;
    localparam t_skip SKIP_IMGDSC = 10'd9;

    localparam t_off OFF_VER    = t_off'(3);
    localparam t_off OFF_SCREEN = t_off'(6);
    localparam t_off OFF_LABEL  = t_off'(13);
    localparam t_cnt END_BAD    = t_cnt'(14);
    localparam t_cnt END_FIXED  = t_cnt'(6);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_req;

    typedef struct packed {
        logic [3:0] verdict;
        t_cnt       end_offset;
        t_cnt       byte_count;
        logic       has_overlay;
    } t_out_req;

    function automatic t_skip table_size(input logic [7:0] flags);
        t_skip sz;
        sz = '0;
        if (flags[7]) begin
            sz = t_skip'(t_skip'(3) << ({1'b0, flags[2:0]} + 4'd1));
        end
        return sz;
    endfunction

    function automatic t_off sat_off(input t_sum a, input t_sum b);
        t_sum s;
        s = a + b;
        if (s > OFF_MAX_X) begin
            return {OFFSET_BITS{1'b1}};
        end
        return s[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [3:0] trunc_verdict(input t_phase ph, input logic seen);
        logic [3:0] v;
        unique case (ph)
            PH_SIG, PH_VER:          v = V_NOT_GIF;
            PH_SCREEN:               v = V_TRUNC_SCREEN;
            PH_GCT:                  v = V_TRUNC_GCT;
            PH_LABEL:                v = seen ? V_NO_TRAILER : V_TRUNC_LABEL;
            PH_EXTLABEL, PH_EXTSIZE: v = V_TRUNC_EXT;
            PH_EXTSUB:               v = V_TRUNC_EXTSUB;
            PH_IMGDESC:              v = V_TRUNC_IMGDESC;
            default:                 v = V_TRUNC_IMG;
        endcase
        return v;
    endfunction

endpackage

/* sv/gbsc_core.sv */
// Parse state and block-walk logic: one file byte per step, verdict on the last byte.
// Depends on gbsc_pkg.
module gbsc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  gbsc_pkg::t_in_req  i_item,
    output logic               o_res_valid,
    output gbsc_pkg::t_out_req o_res
);

    gbsc_pkg::t_phase r_phase, n_phase;
    gbsc_pkg::t_skip  r_skip, n_skip;
    gbsc_pkg::t_skip  r_tlen, n_tlen;
    gbsc_pkg::t_off   r_lo, n_lo;
    gbsc_pkg::t_cnt   r_pos, n_pos;
    logic             r_seen, n_seen;
    logic [3:0]       r_verdict, n_verdict;
    logic             r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.is_last)) begin
            r_phase   <= gbsc_pkg::PH_SIG;
            r_skip    <= '0;
            r_tlen    <= '0;
            r_lo      <= '0;
            r_pos     <= '0;
            r_seen    <= 1'b0;
            r_verdict <= '0;
            r_done    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_tlen    <= n_tlen;
            r_lo      <= n_lo;
            r_pos     <= n_pos;
            r_seen    <= n_seen;
            r_verdict <= n_verdict;
            r_done    <= n_done;
        end
    end

    always_comb begin
        logic [7:0]      b;
        gbsc_pkg::t_skip dec;
        gbsc_pkg::t_skip tl;
        gbsc_pkg::t_sum  lo_x;
        gbsc_pkg::t_sum  p_x;
        logic [7:0]      want;

        b    = i_item.data_byte;
        dec  = (r_skip != '0) ? r_skip - gbsc_pkg::t_skip'(1) : '0;
        lo_x = gbsc_pkg::t_sum'(r_lo);
        p_x  = gbsc_pkg::t_sum'(r_pos);
        tl   = r_tlen;
        want = (r_pos == '0) ? gbsc_pkg::SIG_G :
               (r_pos == gbsc_pkg::t_cnt'(1)) ? gbsc_pkg::SIG_I : gbsc_pkg::SIG_F;

        n_phase   = r_phase;
        n_skip    = r_skip;
        n_tlen    = r_tlen;
        n_lo      = r_lo;
        n_seen    = r_seen;
        n_verdict = r_verdict;
        n_done    = r_done;
        n_pos     = (r_pos != gbsc_pkg::CNT_MAX) ? r_pos + gbsc_pkg::t_cnt'(1) : r_pos;

        if (!r_done) begin
            unique case (r_phase)
                gbsc_pkg::PH_SIG: begin
                    if (b != want) begin
                        n_verdict = gbsc_pkg::V_NOT_GIF;
                        n_done    = 1'b1;
                    end else if (r_pos >= gbsc_pkg::t_cnt'(2)) begin
                        n_lo    = gbsc_pkg::OFF_VER;
                        n_phase = gbsc_pkg::PH_VER;
                        n_skip  = gbsc_pkg::SKIP_VER;
                    end
                end
                gbsc_pkg::PH_VER: begin
                    n_skip = dec;
                    if (dec == '0) begin
                        n_lo    = gbsc_pkg::OFF_SCREEN;
                        n_phase = gbsc_pkg::PH_SCREEN;
                        n_skip  = gbsc_pkg::SKIP_SCREEN;
                    end
                end
                gbsc_pkg::PH_SCREEN: begin
                    if (r_skip == gbsc_pkg::SKIP_FLAGS) begin
                        tl = gbsc_pkg::table_size(b);
                    end
                    n_tlen = tl;
                    n_skip = dec;
                    if (dec == '0) begin
                        n_lo = gbsc_pkg::OFF_LABEL;
                        if (tl != '0) begin
                            n_phase = gbsc_pkg::PH_GCT;
                            n_skip  = tl;
                        end else begin
                            n_phase = gbsc_pkg::PH_LABEL;
                        end
                    end
                end
                gbsc_pkg::PH_GCT, gbsc_pkg::PH_EXTSUB, gbsc_pkg::PH_IMGSUB: begin
                    n_skip = dec;
                    if (dec == '0) begin
                        n_lo = gbsc_pkg::sat_off(p_x, gbsc_pkg::t_sum'(1));
                        n_phase = (r_phase == gbsc_pkg::PH_GCT)    ? gbsc_pkg::PH_LABEL :
                                  (r_phase == gbsc_pkg::PH_EXTSUB) ? gbsc_pkg::PH_EXTSIZE :
                                                                     gbsc_pkg::PH_IMGSIZE;
                    end
                end
                gbsc_pkg::PH_IMGDESC: begin
                    n_skip = dec;
                    if (dec == '0) begin
                        n_lo = gbsc_pkg::sat_off(lo_x,
                            gbsc_pkg::t_sum'(gbsc_pkg::table_size(b)) + gbsc_pkg::t_sum'(10));
                        n_phase = gbsc_pkg::PH_IMGSIZE;
                    end
                end
                gbsc_pkg::PH_LABEL, gbsc_pkg::PH_EXTLABEL,
                gbsc_pkg::PH_EXTSIZE, gbsc_pkg::PH_IMGSIZE: begin
                    if (p_x >= lo_x) begin
                        n_lo = gbsc_pkg::sat_off(lo_x, gbsc_pkg::t_sum'(1));
                        case (r_phase)
                            gbsc_pkg::PH_LABEL: begin
                                if (b == gbsc_pkg::LBL_TRAILER) begin
                                    n_verdict = gbsc_pkg::V_OK;
                                    n_done    = 1'b1;
                                end else if (b == gbsc_pkg::LBL_EXT) begin
                                    n_phase = gbsc_pkg::PH_EXTLABEL;
                                end else if (b == gbsc_pkg::LBL_IMAGE) begin
                                    n_phase = gbsc_pkg::PH_IMGDESC;
                                    n_skip  = gbsc_pkg::SKIP_IMGDSC;
                                end else begin
                                    n_verdict = gbsc_pkg::V_BAD_LABEL;
                                    n_done    = 1'b1;
                                end
                            end
                            gbsc_pkg::PH_EXTLABEL: begin
                                if (b == gbsc_pkg::LBL_GCE) begin
                                    n_lo    = gbsc_pkg::sat_off(lo_x, gbsc_pkg::t_sum'(7));
                                    n_phase = gbsc_pkg::PH_LABEL;
                                end else begin
                                    n_phase = gbsc_pkg::PH_EXTSIZE;
                                end
                            end
                            gbsc_pkg::PH_EXTSIZE: begin
                                if (b == gbsc_pkg::BLK_END) begin
                                    n_phase = gbsc_pkg::PH_LABEL;
                                end else begin
                                    n_phase = gbsc_pkg::PH_EXTSUB;
                                    n_skip  = gbsc_pkg::t_skip'(b);
                                end
                            end
                            default: begin
                                if (b == gbsc_pkg::BLK_END) begin
                                    n_seen  = 1'b1;
                                    n_phase = gbsc_pkg::PH_LABEL;
                                end else begin
                                    n_phase = gbsc_pkg::PH_IMGSUB;
                                    n_skip  = gbsc_pkg::t_skip'(b);
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        logic [3:0]     v;
        gbsc_pkg::t_cnt end_o;

        v = n_done ? n_verdict : gbsc_pkg::trunc_verdict(n_phase, n_seen);
        if (v == gbsc_pkg::V_NOT_GIF) begin
            end_o = n_pos;
        end else begin
            end_o = (gbsc_pkg::t_sum'(n_lo) > gbsc_pkg::CNT_MAX_X) ?
                    gbsc_pkg::CNT_MAX : gbsc_pkg::t_cnt'(n_lo);
            if (v != gbsc_pkg::V_OK && end_o == gbsc_pkg::END_BAD) begin
                end_o = gbsc_pkg::END_FIXED;
            end
        end
        o_res_valid       = i_step && i_item.is_last;
        o_res.verdict     = v;
        o_res.end_offset  = end_o;
        o_res.byte_count  = n_pos;
        o_res.has_overlay = end_o < n_pos;
    end

endmodule

/* sv/gif_block_structure_checker_unit.sv */
// Top level of the GIF block structure checker: request register, parse core, result register.
// Depends on gbsc_pkg and gbsc_core.
//
// Usage:
// The input channel (i_in_valid, o_in_ready, i_in_req) carries one file byte per request,
// with is_last set on the final byte of a file. The output channel (o_out_valid,
// i_out_ready, o_out_req) carries one result per file: verdict, end offset, byte count and
// overlay flag. Bytes before the last produce no result.
// Throughput is one byte per cycle while no last byte waits for the result register; the parse
// step between the request register and the result register is combinational. The last byte
// of a file passes through the request register and then the result register, and waits in
// the request register while the result register is still full. After each last byte the
// parse state returns to the signature phase, so the next file may follow at once.
// Reset clears the parse state and drops any request or result in flight; o_in_ready
// stays low while reset is asserted.
// When the receiver stalls, ordinary bytes keep flowing; a last byte waits in the request
// register until the result register is free, and o_in_ready drops behind it.
module gif_block_structure_checker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gbsc_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gbsc_pkg::t_out_req o_out_req
);

    logic               r_in_valid;
    gbsc_pkg::t_in_req  r_in;
    logic               r_out_valid;
    gbsc_pkg::t_out_req r_out;
    logic               out_free;
    logic               advance;
    logic               res_valid;
    gbsc_pkg::t_out_req res;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in.is_last || out_free);
    assign o_in_ready = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    gbsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held request lost or changed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten while full");

    a_overlay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.has_overlay ==
            (o_out_req.end_offset < o_out_req.byte_count))
        else $error("overlay flag inconsistent");

    a_not_gif_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.verdict == gbsc_pkg::V_NOT_GIF |->
            o_out_req.end_offset == o_out_req.byte_count)
        else $error("non-GIF end offset differs from byte count");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for gif_block_structure_checker_unit: byte requests of directed and
// random GIF streams go in, each verdict request coming out is compared with a prediction.
// Depends on gbsc_pkg and the checker RTL.
module testbench;

    localparam int unsigned    CYCLE_LIMIT = 300000;
    localparam logic [63:0]    OFF_LIMIT   = 64'({gbsc_pkg::OFFSET_BITS{1'b1}});

    typedef enum int unsigned {
        KIND_GCE   = 0,
        KIND_EXT   = 1,
        KIND_IMAGE = 2
    } t_block_kind;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    gbsc_pkg::t_in_req  in_req    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    gbsc_pkg::t_out_req out_req;

    bit          idling       = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned mismatches   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned cycle_count  = 0;

    gbsc_pkg::t_out_req pending_verdicts[$];
    logic [7:0]         file_bytes[$];

    gbsc_pkg::t_phase parse_ph;
    int unsigned      bytes_to_skip;
    int unsigned      table_bytes;
    logic [63:0]      read_off;
    logic [31:0]      byte_pos;
    bit               image_seen;
    bit               verdict_fixed;
    logic [3:0]       verdict_held;

    gif_block_structure_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] off_add(input logic [63:0] a, input logic [63:0] b);
        if (a > OFF_LIMIT || b > OFF_LIMIT - a) begin
            return OFF_LIMIT;
        end
        return a + b;
    endfunction

    function automatic int unsigned colour_table_bytes(input logic [7:0] flags);
        if (!flags[7]) begin
            return 0;
        end
        return 3 << (int'(flags[2:0]) + 1);
    endfunction

    function automatic void clear_parser();
        parse_ph      = gbsc_pkg::PH_SIG;
        bytes_to_skip = 0;
        table_bytes   = 0;
        read_off      = '0;
        byte_pos      = '0;
        image_seen    = 1'b0;
        verdict_fixed = 1'b0;
        verdict_held  = gbsc_pkg::V_OK;
    endfunction

    function automatic void settle(input logic [3:0] v);
        verdict_held  = v;
        verdict_fixed = 1'b1;
    endfunction

    function automatic void skip_region(input logic [31:0] p, input gbsc_pkg::t_phase next);
        if (bytes_to_skip > 0) begin
            bytes_to_skip--;
        end
        if (bytes_to_skip == 0) begin
            read_off = off_add({32'd0, p}, 64'd1);
            parse_ph = next;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input bit last);
        logic [31:0]        p;
        logic [7:0]         want;
        logic [3:0]         v;
        logic [63:0]        fin;
        gbsc_pkg::t_out_req r;
        p = byte_pos;
        if (byte_pos != '1) begin
            byte_pos++;
        end
        if (!verdict_fixed) begin
            case (parse_ph)
                gbsc_pkg::PH_SIG: begin
                    want = (p == 0) ? gbsc_pkg::SIG_G :
                           (p == 1) ? gbsc_pkg::SIG_I : gbsc_pkg::SIG_F;
                    if (b != want) begin
                        settle(gbsc_pkg::V_NOT_GIF);
                    end else if (p >= 2) begin
                        read_off      = 64'd3;
                        parse_ph      = gbsc_pkg::PH_VER;
                        bytes_to_skip = 3;
                    end
                end
                gbsc_pkg::PH_VER: begin
                    if (bytes_to_skip > 0) begin
                        bytes_to_skip--;
                    end
                    if (bytes_to_skip == 0) begin
                        read_off      = 64'd6;
                        parse_ph      = gbsc_pkg::PH_SCREEN;
                        bytes_to_skip = 7;
                    end
                end
                gbsc_pkg::PH_SCREEN: begin
                    if (bytes_to_skip == 3) begin
                        table_bytes = colour_table_bytes(b);
                    end
                    if (bytes_to_skip > 0) begin
                        bytes_to_skip--;
                    end
                    if (bytes_to_skip == 0) begin
                        read_off = 64'd13;
                        if (table_bytes != 0) begin
                            parse_ph      = gbsc_pkg::PH_GCT;
                            bytes_to_skip = table_bytes;
                        end else begin
                            parse_ph = gbsc_pkg::PH_LABEL;
                        end
                    end
                end
                gbsc_pkg::PH_GCT:    skip_region(p, gbsc_pkg::PH_LABEL);
                gbsc_pkg::PH_EXTSUB: skip_region(p, gbsc_pkg::PH_EXTSIZE);
                gbsc_pkg::PH_IMGSUB: skip_region(p, gbsc_pkg::PH_IMGSIZE);
                gbsc_pkg::PH_IMGDESC: begin
                    if (bytes_to_skip > 0) begin
                        bytes_to_skip--;
                    end
                    if (bytes_to_skip == 0) begin
                        read_off = off_add(read_off, 64'(10 + colour_table_bytes(b)));
                        parse_ph = gbsc_pkg::PH_IMGSIZE;
                    end
                end
                default: begin
                    if ({32'd0, p} >= read_off) begin
                        read_off = off_add(read_off, 64'd1);
                        case (parse_ph)
                            gbsc_pkg::PH_LABEL: begin
                                if (b == gbsc_pkg::LBL_TRAILER) begin
                                    settle(gbsc_pkg::V_OK);
                                end else if (b == gbsc_pkg::LBL_EXT) begin
                                    parse_ph = gbsc_pkg::PH_EXTLABEL;
                                end else if (b == gbsc_pkg::LBL_IMAGE) begin
                                    parse_ph      = gbsc_pkg::PH_IMGDESC;
                                    bytes_to_skip = 9;
                                end else begin
                                    settle(gbsc_pkg::V_BAD_LABEL);
                                end
                            end
                            gbsc_pkg::PH_EXTLABEL: begin
                                if (b == gbsc_pkg::LBL_GCE) begin
                                    read_off = off_add(read_off, 64'd6);
                                    parse_ph = gbsc_pkg::PH_LABEL;
                                end else begin
                                    parse_ph = gbsc_pkg::PH_EXTSIZE;
                                end
                            end
                            gbsc_pkg::PH_EXTSIZE: begin
                                if (b == gbsc_pkg::BLK_END) begin
                                    parse_ph = gbsc_pkg::PH_LABEL;
                                end else begin
                                    parse_ph      = gbsc_pkg::PH_EXTSUB;
                                    bytes_to_skip = 32'(b);
                                end
                            end
                            default: begin
                                if (b == gbsc_pkg::BLK_END) begin
                                    image_seen = 1'b1;
                                    parse_ph   = gbsc_pkg::PH_LABEL;
                                end else begin
                                    parse_ph      = gbsc_pkg::PH_IMGSUB;
                                    bytes_to_skip = 32'(b);
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        if (last) begin
            if (verdict_fixed) begin
                v = verdict_held;
            end else begin
                case (parse_ph)
                    gbsc_pkg::PH_SIG, gbsc_pkg::PH_VER:
                        v = gbsc_pkg::V_NOT_GIF;
                    gbsc_pkg::PH_SCREEN:
                        v = gbsc_pkg::V_TRUNC_SCREEN;
                    gbsc_pkg::PH_GCT:
                        v = gbsc_pkg::V_TRUNC_GCT;
                    gbsc_pkg::PH_LABEL:
                        v = image_seen ? gbsc_pkg::V_NO_TRAILER : gbsc_pkg::V_TRUNC_LABEL;
                    gbsc_pkg::PH_EXTLABEL, gbsc_pkg::PH_EXTSIZE:
                        v = gbsc_pkg::V_TRUNC_EXT;
                    gbsc_pkg::PH_EXTSUB:
                        v = gbsc_pkg::V_TRUNC_EXTSUB;
                    gbsc_pkg::PH_IMGDESC:
                        v = gbsc_pkg::V_TRUNC_IMGDESC;
                    default:
                        v = gbsc_pkg::V_TRUNC_IMG;
                endcase
            end
            fin = (v == gbsc_pkg::V_NOT_GIF) ? {32'd0, byte_pos} : read_off;
            if (v != gbsc_pkg::V_OK && v != gbsc_pkg::V_NOT_GIF && fin == 64'd14) begin
                fin = 64'd6;
            end
            r.verdict     = v;
            r.end_offset  = (fin > 64'hFFFF_FFFF) ? '1 : fin[31:0];
            r.byte_count  = byte_pos;
            r.has_overlay = (fin < {32'd0, byte_pos});
            pending_verdicts.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        gbsc_pkg::t_out_req want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual verdict %0d end %0d",
                         $time, out_req.verdict, out_req.end_offset);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("verdict", 32'(want.verdict), 32'(out_req.verdict));
                check_field("end_offset", want.end_offset, out_req.end_offset);
                check_field("byte_count", want.byte_count, out_req.byte_count);
                check_field("has_overlay", 32'(want.has_overlay), 32'(out_req.has_overlay));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!idling) begin
            out_ready <= 1'b1;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            hold_left <= $urandom_range(0, 8);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        gbsc_pkg::t_in_req req;
        req.data_byte = b;
        req.is_last   = last;
        if (idling && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (!in_ready);
        predict_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            send_byte(file_bytes[i], i == n - 1);
        end
    endtask

    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic start_gif(input logic [7:0] flags);
        file_bytes = {};
        file_bytes.push_back(gbsc_pkg::SIG_G);
        file_bytes.push_back(gbsc_pkg::SIG_I);
        file_bytes.push_back(gbsc_pkg::SIG_F);
        repeat (7) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(flags);
        repeat (2) file_bytes.push_back(8'($urandom));
    endtask

    task automatic add_sub_blocks(input bit big);
        int unsigned len;
        repeat (big ? 1 : $urandom_range(0, 2)) begin
            len = big ? 255 : $urandom_range(1, 6);
            file_bytes.push_back(8'(len));
            repeat (len) file_bytes.push_back(8'($urandom));
        end
        file_bytes.push_back(gbsc_pkg::BLK_END);
    endtask

    task automatic build_gif(input bit big);
        logic [7:0]  flags;
        logic [7:0]  lbl;
        t_block_kind kind;
        flags      = 8'($urandom);
        flags[2:0] = big ? 3'd6 : 3'($urandom_range(0, 2));
        flags[7]   = flags[7] | big;
        start_gif(flags);
        repeat (colour_table_bytes(flags)) file_bytes.push_back(8'($urandom));
        repeat (big ? 1 : $urandom_range(0, 3)) begin
            kind = big ? KIND_EXT : t_block_kind'($urandom_range(0, 2));
            case (kind)
                KIND_GCE: begin
                    file_bytes.push_back(gbsc_pkg::LBL_EXT);
                    file_bytes.push_back(gbsc_pkg::LBL_GCE);
                    repeat (6) file_bytes.push_back(8'($urandom));
                end
                KIND_EXT: begin
                    lbl = 8'($urandom);
                    if (lbl == gbsc_pkg::LBL_GCE) begin
                        lbl = 8'hFE;
                    end
                    file_bytes.push_back(gbsc_pkg::LBL_EXT);
                    file_bytes.push_back(lbl);
                    add_sub_blocks(big);
                end
                default: begin
                    file_bytes.push_back(gbsc_pkg::LBL_IMAGE);
                    repeat (8) file_bytes.push_back(8'($urandom));
                    flags      = 8'($urandom);
                    flags[2:0] = 3'($urandom_range(0, 1));
                    file_bytes.push_back(flags);
                    repeat (colour_table_bytes(flags)) file_bytes.push_back(8'($urandom));
                    file_bytes.push_back(8'($urandom));
                    add_sub_blocks(big);
                end
            endcase
        end
        if ($urandom_range(0, 7) != 0) begin
            file_bytes.push_back(gbsc_pkg::LBL_TRAILER);
        end
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
    endtask

    task automatic test_signature();
        file_bytes = {8'hFF};
        send_file(1);
        file_bytes = {8'h00};
        send_file(1);
        file_bytes = {gbsc_pkg::SIG_G, gbsc_pkg::SIG_I, 8'h58};
        send_file(3);
        file_bytes = {gbsc_pkg::SIG_G, gbsc_pkg::SIG_I, gbsc_pkg::SIG_F, 8'h38};
        send_file(4);
    endtask

    task automatic test_recovery_rule();
        start_gif(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(gbsc_pkg::LBL_TRAILER);
        file_bytes.push_back(8'h00);
        send_file(file_bytes.size());
        start_gif(8'h00);
        file_bytes.push_back(gbsc_pkg::LBL_TRAILER);
        send_file(file_bytes.size());
    endtask

    task automatic test_unchecked_skip();
        start_gif(8'h00);
        file_bytes.push_back(gbsc_pkg::LBL_EXT);
        file_bytes.push_back(gbsc_pkg::LBL_GCE);
        send_file(file_bytes.size());
    endtask

    task automatic test_large_blocks();
        build_gif(1'b1);
        send_file(file_bytes.size());
    endtask

    task automatic test_valid_streams();
        int unsigned stop_at;
        bit          paused;
        stop_at = bytes_sent + 180;
        paused  = 1'b0;
        while (bytes_sent < stop_at) begin
            build_gif(1'b0);
            send_file(file_bytes.size());
            if (!paused && bytes_sent + 90 > stop_at) begin
                wait_for_verdicts();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_broken_streams();
        int unsigned stop_at;
        stop_at = bytes_sent + 130;
        while (bytes_sent < stop_at) begin
            build_gif(1'b0);
            if ($urandom_range(0, 1) == 0) begin
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
                send_file(file_bytes.size());
            end else begin
                send_file($urandom_range(1, file_bytes.size()));
            end
        end
    endtask

    task automatic test_noise();
        int unsigned stop_at;
        int unsigned len;
        stop_at = bytes_sent + 50;
        while (bytes_sent < stop_at) begin
            len        = $urandom_range(1, 6);
            file_bytes = {};
            repeat (len) file_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                file_bytes[0] = gbsc_pkg::SIG_G;
            end
            if (len > 1 && $urandom_range(0, 1) == 0) begin
                file_bytes[1] = gbsc_pkg::SIG_I;
            end
            send_file(len);
        end
    endtask

    task automatic test_back_to_back();
        int unsigned stop_at;
        stop_at = bytes_sent + 80;
        while (bytes_sent < stop_at) begin
            build_gif(1'b0);
            send_file(file_bytes.size());
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        clear_parser();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idling = 1'b1;
        test_signature();
        test_recovery_rule();
        test_unchecked_skip();
        test_large_blocks();
        test_valid_streams();
        test_broken_streams();
        test_noise();
        idling = 1'b0;
        test_back_to_back();
        wait_for_verdicts();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
